>>> rtl/sfr_pkg.sv
`timescale 1ns / 1ps

package sfr_pkg;

   localparam int unsigned HeaderBytes = 2;
   localparam logic [7:0]  CrcPoly     = 8'h07;
   localparam logic [7:0]  CrcInit     = 8'h00;

   typedef enum logic [1:0] {
      PH_WAIT  = 2'd0,
      PH_HEAD  = 2'd1,
      PH_DATA  = 2'd2,
      PH_CHECK = 2'd3
   } phase_type;

   typedef enum logic [2:0] {
      ST_NO_START  = 3'd0,
      ST_START     = 3'd1,
      ST_HEAD_BYTE = 3'd2,
      ST_HEAD_DONE = 3'd3,
      ST_DATA_BYTE = 3'd4,
      ST_DATA_DONE = 3'd5,
      ST_CRC_OK    = 3'd6,
      ST_CRC_FAIL  = 3'd7
   } status_type;

   typedef struct packed {
      status_type status;
      logic [7:0] data_byte;
      logic [7:0] byte_index;
      logic [7:0] frame_length;
      logic [7:0] frame_ident;
      logic [7:0] crc_value;
   } result_type;

   // MSB-first CRC-8, one byte per call
   function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      c = crc ^ b;
      for (int k = 0; k < 8; k++) begin
         if (c[7]) begin
            c = {c[6:0], 1'b0} ^ CrcPoly;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

>>> rtl/sfr_in_reg.sv
`timescale 1ns / 1ps

module sfr_in_reg (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   input  logic       advance,
   output logic       hold_valid,
   output logic [7:0] hold_byte
);

   logic       valid_ff, valid_in;
   logic [7:0] byte_ff,  byte_in;
   logic       take;

   // stall only while a held beat cannot move on this cycle
   assign req_stall = valid_ff && !advance;
   assign take      = req_valid && !req_stall;

   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      if (take) begin
         valid_in = 1'b1;
         byte_in  = req_rx_byte;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end

   assign hold_valid = valid_ff;
   assign hold_byte  = byte_ff;

endmodule

>>> rtl/sfr_frame_core.sv
`timescale 1ns / 1ps

module sfr_frame_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic [7:0]            rx_byte,
   input  logic [7:0]            start_marker,
   output sfr_pkg::result_type   result
);
   import sfr_pkg::*;

   phase_type  phase_ff,  phase_in;
   logic [7:0] pos_ff,    pos_in;
   logic [7:0] crc_ff,    crc_in;
   logic [7:0] len_ff,    len_in;
   logic [7:0] ident_ff,  ident_in;

   logic [7:0] crc_step;
   logic       head_last;
   logic       data_last;
   logic       marker_hit;

   assign crc_step   = crc8_update(crc_ff, rx_byte);
   assign head_last  = pos_ff >= 8'(HeaderBytes - 1);
   assign data_last  = !(({1'b0, pos_ff} + 9'd1) < {1'b0, len_ff});
   assign marker_hit = rx_byte == start_marker;

   // next phase
   always_comb begin
      phase_in = phase_ff;
      unique case (phase_ff)
         PH_WAIT:  if (marker_hit) phase_in = PH_HEAD;
         PH_HEAD:  if (head_last) phase_in = (len_in == 8'd0) ? PH_CHECK : PH_DATA;
         PH_DATA:  if (data_last) phase_in = PH_CHECK;
         PH_CHECK: phase_in = PH_WAIT;
         default:  phase_in = PH_WAIT;
      endcase
   end

   // datapath and result
   always_comb begin
      pos_in   = pos_ff;
      crc_in   = crc_ff;
      len_in   = len_ff;
      ident_in = ident_ff;
      result.status     = ST_NO_START;
      result.byte_index = 8'd0;
      result.crc_value  = crc_ff;
      unique case (phase_ff)
         PH_WAIT: begin
            if (marker_hit) begin
               result.status = ST_START;
               pos_in        = 8'd0;
            end
         end
         PH_HEAD: begin
            if (pos_ff == 8'd0) begin
               len_in = rx_byte;
            end else begin
               ident_in = rx_byte;
            end
            crc_in           = crc_step;
            result.crc_value = crc_step;
            if (head_last) begin
               result.status = ST_HEAD_DONE;
               pos_in        = 8'd0;
            end else begin
               result.status = ST_HEAD_BYTE;
               pos_in        = pos_ff + 8'd1;
            end
         end
         PH_DATA: begin
            result.byte_index = pos_ff;
            crc_in            = crc_step;
            result.crc_value  = crc_step;
            if (data_last) begin
               result.status = ST_DATA_DONE;
               pos_in        = 8'd0;
            end else begin
               result.status = ST_DATA_BYTE;
               pos_in        = pos_ff + 8'd1;
            end
         end
         PH_CHECK: begin
            result.status = (rx_byte == crc_ff) ? ST_CRC_OK : ST_CRC_FAIL;
            crc_in        = CrcInit;
            pos_in        = 8'd0;
         end
         default: begin
            pos_in = 8'd0;
         end
      endcase
      result.data_byte    = rx_byte;
      result.frame_length = len_in;
      result.frame_ident  = ident_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_WAIT;
         pos_ff   <= 8'd0;
         crc_ff   <= CrcInit;
         len_ff   <= 8'd0;
         ident_ff <= 8'd0;
      end else if (advance) begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         crc_ff   <= crc_in;
         len_ff   <= len_in;
         ident_ff <= ident_in;
      end
   end

endmodule

>>> rtl/sfr_out_reg.sv
`timescale 1ns / 1ps

module sfr_out_reg (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  sfr_pkg::result_type result,
   output logic                out_ready,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output sfr_pkg::result_type rsp_result
);
   import sfr_pkg::*;

   logic       valid_ff, valid_in;
   result_type data_ff,  data_in;

   // free when empty or when the held beat leaves this cycle
   assign out_ready = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (load) begin
         valid_in = 1'b1;
         data_in  = result;
      end else if (valid_ff && !rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_valid  = valid_ff;
   assign rsp_result = data_ff;

endmodule

>>> rtl/serial_frame_receiver_crc8_top.sv
`timescale 1ns / 1ps

// Serial frame receiver: takes one received byte per beat and tracks frames laid
// out as start marker, length, identifier, payload, CRC-8 byte (poly 0x07, init 0,
// over header and payload), giving exactly one status beat per byte. A zero length
// skips straight to the CRC byte. The start marker is a register written through
// csr_wr_en / csr_wr_data; write it only while no beat is in flight. Each byte
// passes an input register, then the combinational frame state update and CRC
// step, then a result register; rsp_valid rises once it has passed both. It
// sustains one byte per clock while rsp_stall is low. The input register keeps
// accepting while a finished result is stalled at the output, until both hold.
module serial_frame_receiver_crc8_top (
   input  logic       clock,
   input  logic       reset,
   // input bytes
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   // status beats
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [2:0] rsp_status,
   output logic [7:0] rsp_data_byte,
   output logic [7:0] rsp_byte_index,
   output logic [7:0] rsp_frame_length,
   output logic [7:0] rsp_frame_ident,
   output logic [7:0] rsp_crc_value,
   // start marker register
   input  logic       csr_wr_en,
   input  logic [7:0] csr_wr_data
);
   import sfr_pkg::*;

   logic       hold_valid;
   logic [7:0] hold_byte;
   logic       out_ready;
   logic       advance;
   logic [7:0] marker_ff;
   result_type core_result;
   result_type out_result;

   // move a held byte through the frame logic when the result register frees up
   assign advance = hold_valid && out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         marker_ff <= 8'd0;
      end else if (csr_wr_en) begin
         marker_ff <= csr_wr_data;
      end
   end

   sfr_in_reg u_in_reg (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_rx_byte (req_rx_byte),
      .advance     (advance),
      .hold_valid  (hold_valid),
      .hold_byte   (hold_byte)
   );

   sfr_frame_core u_core (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .rx_byte      (hold_byte),
      .start_marker (marker_ff),
      .result       (core_result)
   );

   sfr_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (advance),
      .result     (core_result),
      .out_ready  (out_ready),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_result (out_result)
   );

   // unpack the result beat onto the ports
   assign rsp_status       = out_result.status;
   assign rsp_data_byte    = out_result.data_byte;
   assign rsp_byte_index   = out_result.byte_index;
   assign rsp_frame_length = out_result.frame_length;
   assign rsp_frame_ident  = out_result.frame_ident;
   assign rsp_crc_value    = out_result.crc_value;

endmodule

>>> rtl/sfr_assert.sv
`timescale 1ns / 1ps

module sfr_assert (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [2:0] rsp_status,
   input logic [7:0] rsp_data_byte,
   input logic [7:0] rsp_byte_index,
   input logic [7:0] rsp_frame_length,
   input logic [7:0] rsp_frame_ident,
   input logic [7:0] rsp_crc_value
);
   import sfr_pkg::*;

   // no result beat right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result beat present after reset");

   // a stalled beat holds
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_data_byte) && $stable(rsp_byte_index)
         && $stable(rsp_crc_value) && $stable(rsp_frame_length)
         && $stable(rsp_frame_ident))
      else $error("stalled result beat changed");

   // payload index only on payload beats
   a_index_payload: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_byte_index != 8'd0 |->
         rsp_status == ST_DATA_BYTE || rsp_status == ST_DATA_DONE)
      else $error("nonzero byte index outside payload");

   // CRC is cleared whenever the receiver waits for a marker
   a_idle_crc: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_NO_START || rsp_status == ST_START) |->
         rsp_crc_value == CrcInit)
      else $error("running CRC not cleared between frames");

endmodule

bind serial_frame_receiver_crc8_top sfr_assert u_sfr_assert (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_status       (rsp_status),
   .rsp_data_byte    (rsp_data_byte),
   .rsp_byte_index   (rsp_byte_index),
   .rsp_frame_length (rsp_frame_length),
   .rsp_frame_ident  (rsp_frame_ident),
   .rsp_crc_value    (rsp_crc_value)
);
